// ===== rtl/core/qftm_pkg.sv =====
// Shared types and constants for the queue with flush-through-match.
// Holds status codes, action codes, controller states and the command and
// status structs passed between the controller and the datapath.
package qftm_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMP,
        ST_POST
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       push;
        logic       scan_next;
        logic       pop_hit;
        logic       res_load;
        logic [1:0] res_code;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic in_action;
        logic full;
        logic empty;
        logic match;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/qftm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module qftm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/qftm_ctrl.sv =====
// Controller state machine for the queue with flush-through-match.
// Depends on qftm_pkg; drives datapath commands from datapath status.
module qftm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  qftm_pkg::sts_t  sts,
    output qftm_pkg::cmd_t  cmd
);

    qftm_pkg::state_t state_reg;
    qftm_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qftm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qftm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (sts.in_action == qftm_pkg::ACT_REMOVE && !sts.empty) begin
                        state_next = qftm_pkg::ST_SCAN;
                    end else begin
                        state_next = qftm_pkg::ST_POST;
                    end
                end
            end
            qftm_pkg::ST_SCAN: begin
                state_next = qftm_pkg::ST_CMP;
            end
            qftm_pkg::ST_CMP: begin
                if (sts.match || sts.scan_last) begin
                    state_next = qftm_pkg::ST_POST;
                end else begin
                    state_next = qftm_pkg::ST_SCAN;
                end
            end
            qftm_pkg::ST_POST: begin
                if (sts.out_free) begin
                    state_next = qftm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qftm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            qftm_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    if (sts.in_action == qftm_pkg::ACT_APPEND) begin
                        cmd.res_load = 1'b1;
                        if (sts.full) begin
                            cmd.res_code = qftm_pkg::STATUS_OVERFLOW;
                        end else begin
                            cmd.push     = 1'b1;
                            cmd.res_code = qftm_pkg::STATUS_OK;
                        end
                    end else if (sts.empty) begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = qftm_pkg::STATUS_EMPTY;
                    end
                end
            end
            qftm_pkg::ST_SCAN: begin
                cmd = '0;
            end
            qftm_pkg::ST_CMP: begin
                if (sts.match) begin
                    cmd.pop_hit  = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_code = qftm_pkg::STATUS_OK;
                end else if (sts.scan_last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = qftm_pkg::STATUS_NOT_FOUND;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            qftm_pkg::ST_POST: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/qftm_dp.sv =====
// Datapath for the queue with flush-through-match: circular entry store,
// head/tail/count, scan pointer, result and output registers.
// Depends on qftm_pkg and qftm_ram.
module qftm_dp #(
    parameter int DEPTH = qftm_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_action,
    input  logic signed [31:0]                  in_value,
    input  qftm_pkg::cmd_t                      cmd,
    output qftm_pkg::sts_t                      sts,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [qftm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic signed [31:0] value_reg;
    logic [1:0]         res_status_reg;
    logic [3:0]         res_count_reg;
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [3:0]         out_count_reg;
    logic [31:0]        rd_data;
    logic [CW-1:0]      idx_inc;
    logic [CW+3:0]      count_ext;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    qftm_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (tail_reg),
        .wr_data (in_value),
        .rd_addr (scan_ptr_reg),
        .rd_data (rd_data)
    );

    assign idx_inc = idx_reg + 1'b1;

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        scan_ptr_next = scan_ptr_reg;
        idx_next      = idx_reg;
        if (cmd.capture) begin
            scan_ptr_next = head_reg;
            idx_next      = '0;
        end
        if (cmd.push) begin
            tail_next  = wrap_inc(tail_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.scan_next) begin
            scan_ptr_next = wrap_inc(scan_ptr_reg);
            idx_next      = idx_inc;
        end
        if (cmd.pop_hit) begin
            head_next  = wrap_inc(scan_ptr_reg);
            count_next = count_reg - idx_inc;
        end
    end

    assign count_ext = {4'b0000, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_ptr_reg <= scan_ptr_next;
        idx_reg      <= idx_next;
        if (cmd.capture) begin
            value_reg <= in_value;
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_code;
            res_count_reg  <= count_ext[3:0];
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_count_reg  <= res_count_reg;
        end
    end

    always_comb begin
        sts.in_action = in_action;
        sts.full      = (count_reg == CW'(DEPTH));
        sts.empty     = (count_reg == '0);
        sts.match     = (rd_data == value_reg);
        sts.scan_last = (idx_inc == count_reg);
        sts.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_status_reg};

endmodule

// ===== rtl/core/queue_with_flush_through_match.sv =====
// Top level of the queue with flush-through-match.
// Depends on qftm_pkg, qftm_ctrl and qftm_dp.
//
// Usage:
// Input stream (s_): each transfer is one item. action 0 appends value at the
// tail; action 1 searches from the head for the first entry equal to value
// and drops it together with every entry ahead of it.
// Output stream (m_): one transfer per item, carrying the status (ok,
// overflow, empty, not found) and the number of entries held afterwards.
// Items are handled one at a time. An append, or a remove on an empty queue,
// registers its result on the input transfer; the post state then loads it
// into the output register. A remove scans entries (up to the count) through
// the registered read port of the entry RAM, with a scan and a compare state per entry.
// The next input transfer is taken after the post state loads the result.
// Reset empties the queue and clears the output; entry contents are kept.
// A stalled receiver holds the result in the output register; the block
// takes one more item and holds its result until the output register frees.
module queue_with_flush_through_match #(
    parameter int DEPTH = qftm_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] action, [32:1] value, [39:33] zero
    input  logic [qftm_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [5:2] count_after, [7:6] zero
    output logic [qftm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    qftm_pkg::cmd_t cmd;
    qftm_pkg::sts_t sts;

    qftm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    qftm_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_action (s_tdata[0]),
        .in_value  (s_tdata[32:1]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
